// ===== hw/rtl/dci_pkg.sv =====
// Package for the rope distance constraint impulse block.
// Holds the fixed-point constants, register indexes and shared types.
// Used by the channel interfaces, dci_csr, dci_core, dci_outbuf and the top module.
package dci_pkg;

   localparam int FracBitsDefault = 16;
   localparam int WordWidth = 32;
   localparam int MassWidth = 31;
   localparam int RestWidth = 31;
   localparam int BiasWidth = 17;
   localparam int StepWidth = 31;
   localparam int CsrAddrWidth = 4;
   localparam int CsrDataWidth = 32;

   localparam logic [CsrAddrWidth-1:0] RegRestLength = 4'd0;
   localparam logic [CsrAddrWidth-1:0] RegBiasFactor = 4'd4;
   localparam logic [CsrAddrWidth-1:0] RegTimeStep = 4'd8;

   localparam logic [StepWidth-1:0] TimeStepReset = 31'd1092;

   typedef struct packed {
      logic signed [WordWidth-1:0] pos_a_x;
      logic signed [WordWidth-1:0] pos_a_y;
      logic signed [WordWidth-1:0] pos_a_z;
      logic signed [WordWidth-1:0] pos_b_x;
      logic signed [WordWidth-1:0] pos_b_y;
      logic signed [WordWidth-1:0] pos_b_z;
      logic signed [WordWidth-1:0] rel_vel_x;
      logic signed [WordWidth-1:0] rel_vel_y;
      logic signed [WordWidth-1:0] rel_vel_z;
      logic [MassWidth-1:0] inv_mass_a;
      logic [MassWidth-1:0] inv_mass_b;
   } req_type;

   typedef struct packed {
      logic signed [WordWidth-1:0] impulse_x;
      logic signed [WordWidth-1:0] impulse_y;
      logic signed [WordWidth-1:0] impulse_z;
      logic signed [WordWidth-1:0] dvel_a_x;
      logic signed [WordWidth-1:0] dvel_a_y;
      logic signed [WordWidth-1:0] dvel_a_z;
      logic signed [WordWidth-1:0] dvel_b_x;
      logic signed [WordWidth-1:0] dvel_b_y;
      logic signed [WordWidth-1:0] dvel_b_z;
      logic stretched;
      logic engaged;
   } rsp_type;

   typedef struct packed {
      logic [RestWidth-1:0] rest_length;
      logic [BiasWidth-1:0] bias_factor;
      logic [StepWidth-1:0] time_step;
   } cfg_type;

endpackage

// ===== hw/rtl/dci_req_if.sv =====
// Request channel interface: valid, ready and the body pair payload.
// Depends on dci_pkg for the payload type.
interface dci_req_if;
   logic valid;
   logic ready;
   dci_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/dci_rsp_if.sv =====
// Result channel interface: valid, ready and the impulse payload.
// Depends on dci_pkg for the payload type.
interface dci_rsp_if;
   logic valid;
   logic ready;
   dci_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/dci_csr.sv =====
// Configuration register file behind the APB-style write port.
// Depends on dci_pkg for register indexes and the configuration type.
module dci_csr (
   input  logic clock,
   input  logic reset,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [dci_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [dci_pkg::CsrDataWidth-1:0] csr_pwdata,
   output logic [dci_pkg::CsrDataWidth-1:0] csr_prdata,
   output logic csr_pready,
   output dci_pkg::cfg_type cfg
);
   dci_pkg::cfg_type cfg_ff;
   logic wr;

   assign wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rest_length <= '0;
         cfg_ff.bias_factor <= '0;
         cfg_ff.time_step <= dci_pkg::TimeStepReset;
      end else if (wr) begin
         unique case (csr_paddr)
            dci_pkg::RegRestLength: cfg_ff.rest_length <= csr_pwdata[dci_pkg::RestWidth-1:0];
            dci_pkg::RegBiasFactor: cfg_ff.bias_factor <= csr_pwdata[dci_pkg::BiasWidth-1:0];
            dci_pkg::RegTimeStep: cfg_ff.time_step <= csr_pwdata[dci_pkg::StepWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr)
         dci_pkg::RegRestLength: csr_prdata = {1'b0, cfg_ff.rest_length};
         dci_pkg::RegBiasFactor: csr_prdata = {15'd0, cfg_ff.bias_factor};
         dci_pkg::RegTimeStep: csr_prdata = {1'b0, cfg_ff.time_step};
         default: csr_prdata = '0;
      endcase
   end
endmodule

// ===== hw/rtl/dci_divstage.sv =====
// One pipelined restoring-division step: one quotient bit per stage.
// Standalone; moves a remainder, quotient, divisor and side payload with valid.
module dci_divstage #(
   parameter int NumWidth = 64,
   parameter int DenWidth = 64,
   parameter int SideWidth = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic in_valid,
   input  logic [NumWidth-1:0] in_num,
   input  logic [DenWidth:0] in_rem,
   input  logic [DenWidth-1:0] in_den,
   input  logic [SideWidth-1:0] in_side,
   output logic out_valid,
   output logic [NumWidth-1:0] out_num,
   output logic [DenWidth:0] out_rem,
   output logic [DenWidth-1:0] out_den,
   output logic [SideWidth-1:0] out_side
);
   logic valid_ff;
   logic [NumWidth-1:0] num_ff, num_in;
   logic [DenWidth:0] rem_ff, rem_in, trial;
   logic [DenWidth-1:0] den_ff;
   logic [SideWidth-1:0] side_ff;

   always_comb begin
      trial = {in_rem[DenWidth-1:0], in_num[NumWidth-1]};
      if (trial >= {1'b0, in_den}) begin
         rem_in = trial - {1'b0, in_den};
         num_in = {in_num[NumWidth-2:0], 1'b1};
      end else begin
         rem_in = trial;
         num_in = {in_num[NumWidth-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
         den_ff <= in_den;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_num = num_ff;
   assign out_rem = rem_ff;
   assign out_den = den_ff;
   assign out_side = side_ff;
endmodule

// ===== hw/rtl/dci_divider.sv =====
// Pipelined unsigned divider built from a chain of one-bit step stages.
// Depends on dci_divstage.
module dci_divider #(
   parameter int NumWidth = 64,
   parameter int DenWidth = 64,
   parameter int SideWidth = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic in_valid,
   input  logic [NumWidth-1:0] in_num,
   input  logic [DenWidth-1:0] in_den,
   input  logic [SideWidth-1:0] in_side,
   output logic out_valid,
   output logic [NumWidth-1:0] out_quot,
   output logic [DenWidth-1:0] out_rem,
   output logic [SideWidth-1:0] out_side
);
   logic v [NumWidth+1];
   logic [NumWidth-1:0] n [NumWidth+1];
   logic [DenWidth:0] r [NumWidth+1];
   logic [DenWidth-1:0] d [NumWidth+1];
   logic [SideWidth-1:0] s [NumWidth+1];

   assign v[0] = in_valid;
   assign n[0] = in_num;
   assign r[0] = '0;
   assign d[0] = in_den;
   assign s[0] = in_side;

   for (genvar g = 0; g < NumWidth; g++) begin : g_step
      dci_divstage #(.NumWidth(NumWidth), .DenWidth(DenWidth), .SideWidth(SideWidth)) u_st (
         .clock(clock), .reset(reset), .advance(advance),
         .in_valid(v[g]), .in_num(n[g]), .in_rem(r[g]), .in_den(d[g]), .in_side(s[g]),
         .out_valid(v[g+1]), .out_num(n[g+1]), .out_rem(r[g+1]), .out_den(d[g+1]),
         .out_side(s[g+1])
      );
   end

   assign out_valid = v[NumWidth];
   assign out_quot = n[NumWidth];
   assign out_rem = r[NumWidth][DenWidth-1:0];
   assign out_side = s[NumWidth];
endmodule

// ===== hw/rtl/dci_core.sv =====
// Constraint datapath: length, square root, direction, bias, lambda, impulses.
// Depends on dci_pkg and dci_divider; stalls as one unit on advance.
module dci_core #(
   parameter int FracBits = dci_pkg::FracBitsDefault
) (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  dci_pkg::cfg_type cfg,
   input  logic in_valid,
   input  dci_pkg::req_type in_req,
   output logic out_valid,
   output dci_pkg::rsp_type out_rsp
);
   localparam int SqW = 68;
   localparam int RtW = 34;
   localparam int DirNumW = 33 + FracBits;
   localparam int NumW = 52;
   localparam int LamNumW = NumW + FracBits;
   localparam int LamCap = 32 - FracBits;

   // Stage 1: differences.
   logic v1_ff;
   logic signed [32:0] d1_ff [3];
   logic signed [31:0] rv1_ff [3];
   logic [31:0] ma1_ff, mb1_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (advance) v1_ff <= in_valid;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         d1_ff[0] <= 33'(in_req.pos_a_x) - 33'(in_req.pos_b_x);
         d1_ff[1] <= 33'(in_req.pos_a_y) - 33'(in_req.pos_b_y);
         d1_ff[2] <= 33'(in_req.pos_a_z) - 33'(in_req.pos_b_z);
         rv1_ff[0] <= in_req.rel_vel_x;
         rv1_ff[1] <= in_req.rel_vel_y;
         rv1_ff[2] <= in_req.rel_vel_z;
         ma1_ff <= {1'b0, in_req.inv_mass_a};
         mb1_ff <= {1'b0, in_req.inv_mass_b};
      end
   end

   // Stage 2: squares of magnitudes.
   logic v2_ff;
   logic [65:0] sq2_ff [3];
   logic [32:0] mg2_ff [3];
   logic sg2_ff [3];
   logic signed [31:0] rv2_ff [3];
   logic [31:0] ma2_ff, mb2_ff;
   logic [32:0] mg1 [3];

   always_comb begin
      for (int i = 0; i < 3; i++) mg1[i] = d1_ff[i][32] ? 33'(-d1_ff[i]) : 33'(d1_ff[i]);
   end
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (advance) v2_ff <= v1_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            sq2_ff[i] <= 66'(mg1[i]) * 66'(mg1[i]);
            mg2_ff[i] <= mg1[i];
            sg2_ff[i] <= d1_ff[i][32];
            rv2_ff[i] <= rv1_ff[i];
         end
         ma2_ff <= ma1_ff;
         mb2_ff <= mb1_ff;
      end
   end

   // Stage 3: sum of squares.
   logic v3_ff;
   logic [SqW-1:0] ss3_ff;
   logic [32:0] mg3_ff [3];
   logic sg3_ff [3];
   logic signed [31:0] rv3_ff [3];
   logic [31:0] ma3_ff, mb3_ff;

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (advance) v3_ff <= v2_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         ss3_ff <= SqW'(sq2_ff[0]) + SqW'(sq2_ff[1]) + SqW'(sq2_ff[2]);
         mg3_ff <= mg2_ff;
         sg3_ff <= sg2_ff;
         rv3_ff <= rv2_ff;
         ma3_ff <= ma2_ff;
         mb3_ff <= mb2_ff;
      end
   end

   // Square root: one result bit per stage.
   logic sv [RtW+1];
   logic [SqW-1:0] srem [RtW+1];
   logic [RtW-1:0] sroot [RtW+1];
   logic [32:0] smg [RtW+1][3];
   logic ssg [RtW+1][3];
   logic signed [31:0] srv [RtW+1][3];
   logic [31:0] sma [RtW+1];
   logic [31:0] smb [RtW+1];

   assign sv[0] = v3_ff;
   assign srem[0] = ss3_ff;
   assign sroot[0] = '0;
   assign smg[0] = mg3_ff;
   assign ssg[0] = sg3_ff;
   assign srv[0] = rv3_ff;
   assign sma[0] = ma3_ff;
   assign smb[0] = mb3_ff;

   for (genvar g = 0; g < RtW; g++) begin : g_sqrt
      localparam int B = RtW - 1 - g;
      logic v_ff;
      logic [SqW-1:0] rem_ff;
      logic [RtW-1:0] root_ff;
      logic [32:0] mg_ff [3];
      logic sg_ff [3];
      logic signed [31:0] rv_ff [3];
      logic [31:0] ma_ff, mb_ff;
      logic [SqW-1:0] trial;

      // Trial subtrahend (2*root*2^B + 2^(2B)).
      assign trial = (SqW'(sroot[g]) << (B + 1)) + (SqW'(1) << (2 * B));

      always_ff @(posedge clock) begin
         if (reset) v_ff <= 1'b0;
         else if (advance) v_ff <= sv[g];
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            if (srem[g] >= trial) begin
               rem_ff <= srem[g] - trial;
               root_ff <= sroot[g] | (RtW'(1) << B);
            end else begin
               rem_ff <= srem[g];
               root_ff <= sroot[g];
            end
            mg_ff <= smg[g];
            sg_ff <= ssg[g];
            rv_ff <= srv[g];
            ma_ff <= sma[g];
            mb_ff <= smb[g];
         end
      end
      assign sv[g+1] = v_ff;
      assign srem[g+1] = rem_ff;
      assign sroot[g+1] = root_ff;
      assign smg[g+1] = mg_ff;
      assign ssg[g+1] = sg_ff;
      assign srv[g+1] = rv_ff;
      assign sma[g+1] = ma_ff;
      assign smb[g+1] = mb_ff;
   end

   // Stage E: flags, excess and bias product.
   logic [RtW-1:0] len;
   logic stretched_e, engaged_e;
   assign len = sroot[RtW];
   assign stretched_e = len > RtW'(cfg.rest_length);
   assign engaged_e = stretched_e && ((sma[RtW] | smb[RtW]) != 32'd0);

   logic ve_ff, st_e_ff, en_e_ff;
   logic [RtW-1:0] len_e_ff;
   logic [50:0] bp_e_ff;
   logic [32:0] mg_e_ff [3];
   logic sg_e_ff [3];
   logic signed [31:0] rv_e_ff [3];
   logic [31:0] ma_e_ff, mb_e_ff;
   logic [RtW-1:0] excess;
   logic [30:0] ts_eff;

   assign excess = stretched_e ? len - RtW'(cfg.rest_length) : '0;
   assign ts_eff = (cfg.time_step == '0) ? 31'd1 : cfg.time_step;

   always_ff @(posedge clock) begin
      if (reset) ve_ff <= 1'b0;
      else if (advance) ve_ff <= sv[RtW];
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         st_e_ff <= stretched_e;
         en_e_ff <= engaged_e;
         len_e_ff <= (len == '0) ? RtW'(1) : len;
         bp_e_ff <= 51'(excess) * 51'(cfg.bias_factor);
         mg_e_ff <= smg[RtW];
         sg_e_ff <= ssg[RtW];
         rv_e_ff <= srv[RtW];
         ma_e_ff <= sma[RtW];
         mb_e_ff <= smb[RtW];
      end
   end

   // Three direction dividers and the bias divider run side by side.
   localparam int SideA = 1 + 1 + 3 + 96 + 64;
   logic [SideA-1:0] side_a;
   assign side_a = {st_e_ff, en_e_ff, sg_e_ff[0], sg_e_ff[1], sg_e_ff[2],
                    rv_e_ff[0], rv_e_ff[1], rv_e_ff[2], ma_e_ff, mb_e_ff};

   logic [DirNumW-1:0] dq [3];
   logic dv [3];
   logic [RtW-1:0] drm [3];
   logic [SideA-1:0] dside [3];

   for (genvar c = 0; c < 3; c++) begin : g_dir
      dci_divider #(.NumWidth(DirNumW), .DenWidth(RtW), .SideWidth(SideA)) u_div (
         .clock(clock), .reset(reset), .advance(advance),
         .in_valid(ve_ff), .in_num(DirNumW'(mg_e_ff[c]) << FracBits), .in_den(len_e_ff),
         .in_side(side_a), .out_valid(dv[c]), .out_quot(dq[c]), .out_rem(drm[c]),
         .out_side(dside[c])
      );
   end

   // Bias divider padded to the same latency.
   logic [DirNumW-1:0] bq_full;
   logic bv;
   logic [30:0] brm;
   logic [0:0] bside;
   dci_divider #(.NumWidth(DirNumW), .DenWidth(31), .SideWidth(1)) u_bias (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(ve_ff), .in_num(DirNumW'(bp_e_ff >> ((51 > DirNumW) ? 51 - DirNumW : 0))),
      .in_den(ts_eff), .in_side(1'b0), .out_valid(bv), .out_quot(bq_full), .out_rem(brm),
      .out_side(bside)
   );

   // The bias product may exceed the divider width; use a separate wide path.
   logic [50:0] bq;
   logic [50:0] bsh [DirNumW+1];
   for (genvar g = 0; g < DirNumW; g++) begin : g_bdly
      logic [50:0] b_ff;
      always_ff @(posedge clock) begin
         if (advance) b_ff <= bsh[g];
      end
      assign bsh[g+1] = b_ff;
   end
   assign bsh[0] = bp_e_ff;

   // Exact bias division: top part from bias divider when narrow enough.
   logic [30:0] bdiv_ts [DirNumW+1];
   assign bdiv_ts[0] = ts_eff;
   for (genvar g = 0; g < DirNumW; g++) begin : g_tsdly
      logic [30:0] t_ff;
      always_ff @(posedge clock) begin
         if (advance) t_ff <= bdiv_ts[g];
      end
      assign bdiv_ts[g+1] = t_ff;
   end

   // The product fits 51 bits and DirNumW >= 41; handle the rest with a
   // second pass of low bits when needed.
   localparam int Extra = (51 > DirNumW) ? 51 - DirNumW : 0;
   logic [DirNumW+Extra-1:0] bq_ext;
   always_comb begin
      logic [31:0] r;
      logic [DirNumW+Extra-1:0] q;
      r = {1'b0, brm};
      q = (DirNumW+Extra)'(bq_full) << Extra;
      for (int k = Extra - 1; k >= 0; k--) begin
         r = {r[30:0], bsh[DirNumW][k]};
         if (r >= {1'b0, bdiv_ts[DirNumW]}) begin
            r = r - {1'b0, bdiv_ts[DirNumW]};
            q[k] = 1'b1;
         end else begin
            q[k] = 1'b0;
         end
      end
      bq_ext = q;
   end
   assign bq = 51'(bq_ext);

   // Stage D: velocity products.
   logic vd_ff, st_d_ff, en_d_ff;
   logic signed [33:0] dir_d_ff [3];
   logic signed [81:0] vp_d_ff [3];
   logic [50:0] bias_d_ff;
   logic [31:0] ma_d_ff, mb_d_ff;
   logic signed [33:0] dirs [3];
   logic signed [31:0] rvs [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         dirs[c] = dside[0][SideA-3-c] ? -34'(dq[c][32:0]) : 34'(dq[c][32:0]);
      end
      rvs[0] = dside[0][159:128];
      rvs[1] = dside[0][127:96];
      rvs[2] = dside[0][95:64];
   end
   always_ff @(posedge clock) begin
      if (reset) vd_ff <= 1'b0;
      else if (advance) vd_ff <= dv[0];
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         st_d_ff <= dside[0][SideA-1];
         en_d_ff <= dside[0][SideA-2];
         for (int c = 0; c < 3; c++) begin
            dir_d_ff[c] <= dirs[c];
            vp_d_ff[c] <= 82'(dirs[c]) * 82'(rvs[c]);
         end
         bias_d_ff <= bq;
         ma_d_ff <= dside[0][63:32];
         mb_d_ff <= dside[0][31:0];
      end
   end

   // Stage N: numerator, magnitude and sign.
   logic vn_ff, st_n_ff, en_n_ff, ns_n_ff;
   logic signed [33:0] dir_n_ff [3];
   logic [NumW-1:0] nm_n_ff;
   logic [31:0] ma_n_ff, mb_n_ff, mass_n_ff;
   logic signed [81:0] vsum;
   logic [81:0] vmag;
   logic signed [81:0] vdot, num;

   always_comb begin
      vsum = vp_d_ff[0] + vp_d_ff[1] + vp_d_ff[2];
      vmag = vsum[81] ? 82'(-vsum) : 82'(vsum);
      vdot = vsum[81] ? -82'(vmag >> FracBits) : 82'(vmag >> FracBits);
      num = -(82'(bias_d_ff) + vdot);
   end
   always_ff @(posedge clock) begin
      if (reset) vn_ff <= 1'b0;
      else if (advance) vn_ff <= vd_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         st_n_ff <= st_d_ff;
         en_n_ff <= en_d_ff;
         ns_n_ff <= num[81];
         nm_n_ff <= num[81] ? NumW'(-num) : NumW'(num);
         dir_n_ff <= dir_d_ff;
         ma_n_ff <= ma_d_ff;
         mb_n_ff <= mb_d_ff;
         mass_n_ff <= (ma_d_ff + mb_d_ff == 32'd0) ? 32'd1 : ma_d_ff + mb_d_ff;
      end
   end

   // Lambda divider.
   localparam int SideL = 3 + 102 + 64;
   logic [SideL-1:0] side_l, lside;
   logic lv;
   logic [LamNumW-1:0] lq;
   logic [31:0] lrm;
   assign side_l = {st_n_ff, en_n_ff, ns_n_ff, dir_n_ff[0], dir_n_ff[1], dir_n_ff[2],
                    ma_n_ff, mb_n_ff};
   dci_divider #(.NumWidth(LamNumW), .DenWidth(32), .SideWidth(SideL)) u_lam (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(vn_ff), .in_num(LamNumW'(nm_n_ff) << FracBits), .in_den(mass_n_ff),
      .in_side(side_l), .out_valid(lv), .out_quot(lq), .out_rem(lrm), .out_side(lside)
   );

   // Stage L: saturated lambda, impulse products.
   logic vl_ff, st_l_ff, en_l_ff;
   logic signed [67:0] ip_l_ff [3];
   logic [31:0] ma_l_ff, mb_l_ff;
   logic signed [32:0] lam;
   logic [32:0] lmag;
   logic signed [33:0] ldir [3];

   always_comb begin
      lmag = (lq[LamNumW-1:FracBits] >= (LamNumW-FracBits)'(1 << LamCap)) ? 33'h1_0000_0000
             : 33'(lq);
      if (lside[SideL-3]) lam = (lmag > 33'h0_8000_0000) ? -33'sh0_8000_0000 : -33'(lmag);
      else lam = (lmag > 33'h0_7FFF_FFFF) ? 33'sh0_7FFF_FFFF : 33'(lmag);
      ldir[0] = lside[165:132];
      ldir[1] = lside[131:98];
      ldir[2] = lside[97:64];
   end
   always_ff @(posedge clock) begin
      if (reset) vl_ff <= 1'b0;
      else if (advance) vl_ff <= lv;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         st_l_ff <= lside[SideL-1];
         en_l_ff <= lside[SideL-2];
         for (int c = 0; c < 3; c++) ip_l_ff[c] <= 68'(ldir[c]) * 68'(lam);
         ma_l_ff <= lside[63:32];
         mb_l_ff <= lside[31:0];
      end
   end

   function automatic logic signed [31:0] sat_shr(input logic signed [67:0] v);
      logic [67:0] m;
      logic signed [67:0] r;
      m = v[67] ? 68'(-v) : 68'(v);
      m = m >> FracBits;
      r = v[67] ? -68'(m) : 68'(m);
      if (r > 68'sd2147483647) sat_shr = 32'sh7FFF_FFFF;
      else if (r < -68'sd2147483648) sat_shr = 32'sh8000_0000;
      else sat_shr = r[31:0];
   endfunction

   // Stage I: impulse and velocity products.
   logic vi_ff, st_i_ff, en_i_ff;
   logic signed [31:0] imp_i_ff [3];
   logic signed [67:0] pa_i_ff [3], pb_i_ff [3];
   logic signed [31:0] imp [3];

   always_comb begin
      for (int c = 0; c < 3; c++) imp[c] = sat_shr(ip_l_ff[c]);
   end
   always_ff @(posedge clock) begin
      if (reset) vi_ff <= 1'b0;
      else if (advance) vi_ff <= vl_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         st_i_ff <= st_l_ff;
         en_i_ff <= en_l_ff;
         for (int c = 0; c < 3; c++) begin
            imp_i_ff[c] <= imp[c];
            pa_i_ff[c] <= 68'(imp[c]) * 68'({1'b0, ma_l_ff});
            pb_i_ff[c] <= -(68'(imp[c]) * 68'({1'b0, mb_l_ff}));
         end
      end
   end

   // Output stage.
   logic vo_ff;
   dci_pkg::rsp_type rsp_ff;
   always_ff @(posedge clock) begin
      if (reset) vo_ff <= 1'b0;
      else if (advance) vo_ff <= vi_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff.stretched <= st_i_ff;
         rsp_ff.engaged <= en_i_ff;
         rsp_ff.impulse_x <= en_i_ff ? imp_i_ff[0] : '0;
         rsp_ff.impulse_y <= en_i_ff ? imp_i_ff[1] : '0;
         rsp_ff.impulse_z <= en_i_ff ? imp_i_ff[2] : '0;
         rsp_ff.dvel_a_x <= en_i_ff ? sat_shr(pa_i_ff[0]) : '0;
         rsp_ff.dvel_a_y <= en_i_ff ? sat_shr(pa_i_ff[1]) : '0;
         rsp_ff.dvel_a_z <= en_i_ff ? sat_shr(pa_i_ff[2]) : '0;
         rsp_ff.dvel_b_x <= en_i_ff ? sat_shr(pb_i_ff[0]) : '0;
         rsp_ff.dvel_b_y <= en_i_ff ? sat_shr(pb_i_ff[1]) : '0;
         rsp_ff.dvel_b_z <= en_i_ff ? sat_shr(pb_i_ff[2]) : '0;
      end
   end

   assign out_valid = vo_ff;
   assign out_rsp = rsp_ff;

   logic unused;
   assign unused = ^{dv[1], dv[2], drm[0], drm[1], drm[2], dside[1], dside[2], bv,
                     bside, lrm, lside[SideL-4:SideL-4]};
endmodule

// ===== hw/rtl/dci_outbuf.sv =====
// Two-entry skid buffer that parts the pipeline from the result channel.
// Depends on dci_pkg for the result type.
module dci_outbuf (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  dci_pkg::rsp_type in_rsp,
   output logic space,
   output logic out_valid,
   input  logic out_ready,
   output dci_pkg::rsp_type out_rsp
);
   logic [1:0] cnt_ff, cnt_in;
   dci_pkg::rsp_type buf_ff [2];
   logic rd_ptr_ff, wr_ptr_ff;
   logic pop, push;

   assign out_valid = cnt_ff != 2'd0;
   assign out_rsp = buf_ff[rd_ptr_ff];
   assign pop = out_valid && out_ready;
   assign push = in_valid;
   assign space = cnt_ff != 2'd2;
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         if (push) wr_ptr_ff <= !wr_ptr_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (push) buf_ff[wr_ptr_ff] <= in_rsp;
   end
endmodule

// ===== hw/rtl/distance_constraint_impulse.sv =====
// Rope distance constraint impulse engine, one body pair per cycle.
// At 16 fraction bits the pipeline is a 34-stage square root, 49-stage direction
// and bias dividers, a 68-stage lambda divider, nine datapath registers and the
// result buffer. Throughput is one request per cycle; the whole pipeline halts
// together while the result buffer holds two results. Reset is synchronous and
// clears all valid bits; registers reset to rest 0, bias 0 and time step 1092.
module distance_constraint_impulse #(
   parameter int FracBits = dci_pkg::FracBitsDefault
) (
   input  logic clock,
   input  logic reset,
   dci_req_if.sink req,
   dci_rsp_if.source rsp,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [dci_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [dci_pkg::CsrDataWidth-1:0] csr_pwdata,
   output logic [dci_pkg::CsrDataWidth-1:0] csr_prdata,
   output logic csr_pready
);
   dci_pkg::cfg_type cfg;
   dci_pkg::rsp_type core_rsp;
   logic core_valid, advance, space;

   dci_csr u_csr (
      .clock(clock), .reset(reset), .csr_psel(csr_psel), .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite), .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready), .cfg(cfg)
   );

   assign advance = space;
   assign req.ready = advance;

   dci_core #(.FracBits(FracBits)) u_core (
      .clock(clock), .reset(reset), .advance(advance), .cfg(cfg),
      .in_valid(req.valid && advance), .in_req(req.data),
      .out_valid(core_valid), .out_rsp(core_rsp)
   );

   dci_outbuf u_outbuf (
      .clock(clock), .reset(reset), .in_valid(core_valid && advance), .in_rsp(core_rsp),
      .space(space), .out_valid(rsp.valid), .out_ready(rsp.ready), .out_rsp(rsp.data)
   );
endmodule
